// ===== rtl/core/qrr_pkg.sv =====
// ----------------------------------------------------------------------------
// qrr_pkg
// Shared types and constants for the quadratic real roots core.
// ----------------------------------------------------------------------------
package qrr_pkg;

  typedef enum logic [1:0] {
    ST_TWO    = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_NONE   = 2'd2,
    ST_AZERO  = 2'd3
  } status_e;

  localparam int unsigned OUT_BITS = 32;

endpackage

// ===== rtl/core/qrr_if.sv =====
// ----------------------------------------------------------------------------
// qrr_in_if / qrr_out_if
// Valid/ready channels carrying coefficient items and root items.
// ----------------------------------------------------------------------------
interface qrr_in_if #(
  parameter int unsigned WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] root_first;
  logic signed [31:0] root_second;
  logic        [1:0]  root_status;
  logic               saturated;
  modport source (output valid, root_first, root_second, root_status, saturated,
                  input ready);
  modport sink   (input valid, root_first, root_second, root_status, saturated,
                  output ready);
endinterface

// ===== rtl/core/qrr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrr_sqrt_cell
// One stage of the restoring square root: settles one root bit.
// ----------------------------------------------------------------------------
module qrr_sqrt_cell #(
  parameter int unsigned RW = 34,
  parameter int unsigned DW = 68,
  parameter int unsigned K  = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  output logic [DW-1:0] rem_o,
  output logic [RW-1:0] root_o
);
  localparam int unsigned TW = DW + 2;
  logic [TW-1:0] trial;
  logic [DW-1:0] rem_d;
  logic [RW-1:0] root_d;
  logic [DW-1:0] rem_q;
  logic [RW-1:0] root_q;

  // Trial (2r + 2^k) * 2^k subtracted from the remaining radicand.
  always_comb begin
    trial  = (TW'(root_i) << (K + 1)) | (TW'(1) << (2 * K));
    rem_d  = rem_i;
    root_d = root_i;
    if (TW'(rem_i) >= trial) begin
      rem_d  = DW'(TW'(rem_i) - trial);
      root_d = root_i | (RW'(1) << K);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

// ===== rtl/core/qrr_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrr_div_cell
// One stage of the restoring divider: settles one quotient bit for two
// numerators sharing one divisor.
// ----------------------------------------------------------------------------
module qrr_div_cell #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 34,
  parameter int unsigned K  = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] den_i,
  input  logic [NW-1:0] num0_i,
  input  logic [NW-1:0] num1_i,
  output logic [NW-1:0] num0_o,
  output logic [NW-1:0] num1_o,
  output logic [NW-1:0] quo0_o,
  output logic [NW-1:0] quo1_o,
  input  logic [NW-1:0] quo0_i,
  input  logic [NW-1:0] quo1_i
);
  localparam int unsigned XW = NW + DW;
  logic [XW-1:0] sh;
  logic [NW-1:0] n0_d, n1_d, q0_d, q1_d;
  logic [NW-1:0] n0_q, n1_q, q0_q, q1_q;

  // num holds the running remainder; subtract den * 2^K where it fits.
  always_comb begin
    sh   = XW'(den_i) << K;
    n0_d = num0_i;
    n1_d = num1_i;
    q0_d = quo0_i;
    q1_d = quo1_i;
    if (XW'(num0_i) >= sh) begin
      n0_d = NW'(XW'(num0_i) - sh);
      q0_d = quo0_i | (NW'(1) << K);
    end
    if (XW'(num1_i) >= sh) begin
      n1_d = NW'(XW'(num1_i) - sh);
      q1_d = quo1_i | (NW'(1) << K);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q <= n0_d;
      n1_q <= n1_d;
      q0_q <= q0_d;
      q1_q <= q1_d;
    end
  end

  assign num0_o = n0_q;
  assign num1_o = n1_q;
  assign quo0_o = q0_q;
  assign quo1_o = q1_q;
endmodule

// ===== rtl/core/quadratic_real_roots_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_real_roots_core
// Real roots of a*x^2 + b*x + c on signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// One coefficient item enters on in_ch, one root item leaves on out_ch.
// The item flows through a row of cells: two product stages form the
// discriminant, WORD_BITS+2 square root cells settle one root bit each,
// one stage forms the numerators, and WORD_BITS+FRAC_BITS+2 divider cells
// settle one quotient bit each, followed by a saturation stage.
// One item is taken every cycle unless the row stalls. A stage holds while
// the receiver holds ready low on an occupied output stage and every stage
// after it holds a valid item; the valid bit of
// each stage lets bubbles be squeezed out, so an item is accepted while a
// result waits as long as an empty stage remains. Reset clears all valid
// bits; no payload is lost or invented.
// ----------------------------------------------------------------------------
module quadratic_real_roots_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  qrr_in_if.sink    in_ch,
  qrr_out_if.source out_ch
);
  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned PW  = 2 * W + 2;
  localparam int unsigned RW  = W + 2;
  localparam int unsigned NW  = W + 2 + FRAC_BITS;
  localparam int unsigned QN  = NW;
  localparam int unsigned SQN = RW;
  localparam int unsigned DVN = NW;
  localparam int unsigned NST = 2 + SQN + 1 + DVN + 1;

  typedef struct packed {
    logic          neg_a;
    logic          neg_b;
    logic [1:0]    status;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  b_raw;
  } side_t;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] adv;
  logic           out_free;

  assign out_free   = !vld_q[NST-1] || out_ch.ready;
  // Stage i moves when its successor moves or is empty.
  always_comb begin
    adv[NST-1] = out_free;
    for (int i = NST - 2; i >= 0; i--) adv[i] = adv[i+1] || !vld_q[i+1];
  end
  assign in_ch.ready = adv[0] || !vld_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (in_ch.ready) vld_q[0] <= in_ch.valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i] || !vld_q[i]) vld_q[i] <= vld_q[i-1] && adv[i-1];
      end
    end
  end
  // Enable for each stage register.
  logic [NST-1:0] en;
  always_comb begin
    en[0] = in_ch.ready;
    for (int i = 1; i < NST; i++) en[i] = adv[i] || !vld_q[i];
  end

  // Stage 0: magnitudes and products.
  side_t s0_q;
  logic [2*W-1:0] bb0_q, ac0_q;
  logic acn0_q;
  logic [W-1:0] ma, mb, mc;
  always_comb begin
    ma = in_ch.coef_a[W-1] ? W'(-in_ch.coef_a) : W'(in_ch.coef_a);
    mb = in_ch.coef_b[W-1] ? W'(-in_ch.coef_b) : W'(in_ch.coef_b);
    mc = in_ch.coef_c[W-1] ? W'(-in_ch.coef_c) : W'(in_ch.coef_c);
  end
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      bb0_q        <= (2*W)'(mb) * (2*W)'(mb);
      ac0_q        <= (2*W)'(ma) * (2*W)'(mc);
      acn0_q       <= in_ch.coef_a[W-1] ^ in_ch.coef_c[W-1];
      s0_q.neg_a   <= in_ch.coef_a[W-1];
      s0_q.neg_b   <= in_ch.coef_b[W-1];
      s0_q.mag_a   <= ma;
      s0_q.b_raw   <= W'(in_ch.coef_b);
      s0_q.status  <= (ma == '0) ? qrr_pkg::ST_AZERO : qrr_pkg::ST_TWO;
    end
  end

  // Stage 1: discriminant and classification.
  side_t s1_q;
  logic [PW-1:0] d1_q;
  logic [PW-1:0] q4, bbw;
  logic [PW-1:0] dd;
  logic [1:0]    st1;
  always_comb begin
    q4  = PW'(ac0_q) << 2;
    bbw = PW'(bb0_q);
    st1 = s0_q.status;
    dd  = '0;
    if (s0_q.status != qrr_pkg::ST_AZERO) begin
      if (acn0_q && ac0_q != '0) begin
        dd = bbw + q4;
      end else if (bbw > q4) begin
        dd = bbw - q4;
      end else if (bbw == q4) begin
        st1 = qrr_pkg::ST_DOUBLE;
      end else begin
        st1 = qrr_pkg::ST_NONE;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d1_q <= dd;
      s1_q <= {s0_q.neg_a, s0_q.neg_b, st1, s0_q.mag_a, s0_q.b_raw};
    end
  end

  // Square root cells.
  logic [PW-1:0] srem [SQN+1];
  logic [RW-1:0] sroot[SQN+1];
  side_t         sside[SQN+1];
  assign srem[0]  = d1_q;
  assign sroot[0] = '0;
  assign sside[0] = s1_q;
  for (genvar g = 0; g < SQN; g++) begin : g_sqrt
    qrr_sqrt_cell #(.RW(RW), .DW(PW), .K(SQN - 1 - g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en[2+g]),
      .rem_i (srem[g]),
      .root_i(sroot[g]),
      .rem_o (srem[g+1]),
      .root_o(sroot[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en[2+g]) sside[g+1] <= sside[g];
    end
  end

  // Numerator stage: |(-b -/+ s)| << FRAC_BITS and signs.
  localparam int unsigned SE = 2 + SQN;
  side_t         sn_q;
  logic [NW-1:0] n0_q, n1_q;
  logic          ng0_q, ng1_q;
  logic signed [W+2:0] nb, s_s, v0, v1;
  always_comb begin
    nb  = -(W+3)'(signed'(sside[SQN].b_raw));
    s_s = (W+3)'(sroot[SQN]);
    v0  = nb - s_s;
    v1  = nb + s_s;
  end
  always_ff @(posedge clk_i) begin
    if (en[SE]) begin
      sn_q  <= sside[SQN];
      n0_q  <= NW'(v0[W+2] ? -v0 : v0) << FRAC_BITS;
      n1_q  <= NW'(v1[W+2] ? -v1 : v1) << FRAC_BITS;
      ng0_q <= v0[W+2] ^ sside[SQN].neg_a;
      ng1_q <= v1[W+2] ^ sside[SQN].neg_a;
    end
  end

  // Divider cells.
  logic [NW-1:0] dn0[DVN+1], dn1[DVN+1], dq0[DVN+1], dq1[DVN+1];
  side_t         dside[DVN+1];
  logic          dg0[DVN+1], dg1[DVN+1];
  assign dn0[0] = n0_q;
  assign dn1[0] = n1_q;
  assign dq0[0] = '0;
  assign dq1[0] = '0;
  assign dside[0] = sn_q;
  assign dg0[0] = ng0_q;
  assign dg1[0] = ng1_q;
  for (genvar g = 0; g < DVN; g++) begin : g_div
    qrr_div_cell #(.NW(NW), .DW(W+1), .K(DVN - 1 - g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en[SE+1+g]),
      .den_i ({dside[g].mag_a, 1'b0}),
      .num0_i(dn0[g]),
      .num1_i(dn1[g]),
      .num0_o(dn0[g+1]),
      .num1_o(dn1[g+1]),
      .quo0_o(dq0[g+1]),
      .quo1_o(dq1[g+1]),
      .quo0_i(dq0[g]),
      .quo1_i(dq1[g])
    );
    always_ff @(posedge clk_i) begin
      if (en[SE+1+g]) begin
        dside[g+1] <= dside[g];
        dg0[g+1]   <= dg0[g];
        dg1[g+1]   <= dg1[g];
      end
    end
  end

  // Saturation and output register.
  localparam logic [NW-1:0] LIM_P = NW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [NW-1:0] LIM_N = NW'(64'd1 << (W - 1));
  logic [NW-1:0] m0, m1;
  logic          c0, c1, zr;
  logic [W-1:0]  r0, r1;
  always_comb begin
    zr = (dside[DVN].status == qrr_pkg::ST_NONE) ||
         (dside[DVN].status == qrr_pkg::ST_AZERO);
    c0 = dq0[DVN] > (dg0[DVN] ? LIM_N : LIM_P);
    c1 = dq1[DVN] > (dg1[DVN] ? LIM_N : LIM_P);
    m0 = c0 ? (dg0[DVN] ? LIM_N : LIM_P) : dq0[DVN];
    m1 = c1 ? (dg1[DVN] ? LIM_N : LIM_P) : dq1[DVN];
    r0 = dg0[DVN] ? W'(-m0) : W'(m0);
    r1 = dg1[DVN] ? W'(-m1) : W'(m1);
  end
  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      out_ch.root_first  <= zr ? '0 : qrr_pkg::OUT_BITS'(signed'(r0));
      out_ch.root_second <= zr ? '0 : qrr_pkg::OUT_BITS'(signed'(r1));
      out_ch.root_status <= dside[DVN].status;
      out_ch.saturated   <= !zr && (c0 || c1);
    end
  end
  assign out_ch.valid = vld_q[NST-1];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.root_first))
    else $error("output changed under stall");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.root_status == qrr_pkg::ST_NONE ||
    out_ch.root_status == qrr_pkg::ST_AZERO) |-> out_ch.root_first == '0 &&
    !out_ch.saturated)
    else $error("nonzero root without real roots");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
endmodule
